// ===== rtl/core/minmod_slope_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// Minmod slope limiter assertion macros
// Shared helpers for the concurrent checks of the slope limiter core.
// ----------------------------------------------------------------------------
`ifndef MINMOD_SLOPE_LIMITER_DEFINES_SVH
`define MINMOD_SLOPE_LIMITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMSL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mmsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Minmod slope limiter package
// Shared defaults, sequencer states and divider control for the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmsl_pkg;

	localparam int unsigned DATA_WIDTH_DEF    = 32;
	localparam int unsigned FRACTION_BITS_DEF = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} mmsl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} mmsl_div_ctrl_t;

endpackage

// ===== rtl/core/minmod_slope_limiter.sv =====
// ----------------------------------------------------------------------------
// Minmod slope limiter, non-uniform grid
// Keeps a two-point window of grid points and emits the minmod-limited slopes
// of velocity, sound speed and pressure at each interior point.
//
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         position, velocity, sound_speed, pressure   restart
// m_axis    out        velocity_slope, sound_speed_slope,          spacing_fault
//                      pressure_slope
//
// An interior point is accepted in idle, then steps through the prepare, load,
// divide, finish and output states; in divide the six bit-serial dividers retire
// one quotient bit per cycle. A point with a non-positive spacing skips from
// prepare to output, and a restart or window-filling point gives no result.
// Reset clears the window, fill count, sequencer and output valid flag.
// A stalled output holds its result while the next point is being accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "minmod_slope_limiter_defines.svh"

module minmod_slope_limiter #(
	parameter int unsigned DATA_WIDTH    = mmsl_pkg::DATA_WIDTH_DEF,
	parameter int unsigned FRACTION_BITS = mmsl_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// position, velocity, sound_speed, pressure
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	// restart
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// velocity_slope, sound_speed_slope, pressure_slope
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
	// spacing_fault
	output logic                                 m_axis_tuser
);

	localparam int unsigned DW    = DATA_WIDTH;
	localparam int unsigned OUT_W = ((3*DATA_WIDTH+7)/8)*8;
	localparam int unsigned CW    = $clog2(DATA_WIDTH);
	localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH-1);

	mmsl_pkg::mmsl_state_t    state_q, state_d;
	mmsl_pkg::mmsl_div_ctrl_t div_ctrl;

	logic [CW-1:0]            cnt_q;
	logic [1:0]               fill_q;
	logic [DW-1:0]            win_pos_q [0:1];
	logic [DW-1:0]            win_qty_q [0:2][0:1];

	logic [DW-1:0]            in_pos;
	logic [DW-1:0]            in_qty [0:2];
	logic                     in_acc;
	logic                     out_load;

	logic signed [DW:0]       dl_q, dr_q;
	logic signed [DW:0]       dq_l_q [0:2];
	logic signed [DW:0]       dq_r_q [0:2];
	logic [DW:0]              mag_l_q [0:2];
	logic [DW:0]              mag_r_q [0:2];
	logic                     neg_l_q [0:2];
	logic                     neg_r_q [0:2];
	logic                     fault_q;

	logic [DW-1:0]            sl [0:2];
	logic [DW-1:0]            sr [0:2];
	logic [DW-1:0]            mm [0:2];

	logic                     out_valid_q;
	logic                     out_fault_q;
	logic [DW-1:0]            out_slope_q [0:2];

	assign in_pos    = s_axis_tdata[DW-1:0];
	assign in_qty[0] = s_axis_tdata[2*DW-1:DW];
	assign in_qty[1] = s_axis_tdata[3*DW-1:2*DW];
	assign in_qty[2] = s_axis_tdata[4*DW-1:3*DW];
	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign out_load  = (state_q == mmsl_pkg::ST_OUT) & (~out_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		div_ctrl        = '0;
		s_axis_tready   = 1'b0;
		case (state_q)
			mmsl_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && !s_axis_tuser && fill_q == 2'd2) begin
					state_d = mmsl_pkg::ST_PREP;
				end
			end
			mmsl_pkg::ST_PREP: begin
				if (dl_q <= 0 || dr_q <= 0) begin
					state_d = mmsl_pkg::ST_OUT;
				end else begin
					state_d = mmsl_pkg::ST_LOAD;
				end
			end
			mmsl_pkg::ST_LOAD: begin
				div_ctrl.load = 1'b1;
				state_d       = mmsl_pkg::ST_DIV;
			end
			mmsl_pkg::ST_DIV: begin
				div_ctrl.step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = mmsl_pkg::ST_FIN;
				end
			end
			mmsl_pkg::ST_FIN: begin
				div_ctrl.finish = 1'b1;
				state_d         = mmsl_pkg::ST_OUT;
			end
			mmsl_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = mmsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mmsl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fill_q <= 2'd0;
		end else begin
			if (state_q == mmsl_pkg::ST_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == mmsl_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (in_acc) begin
				if (s_axis_tuser) begin
					fill_q <= 2'd1;
				end else if (fill_q != 2'd2) begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_pos_q[0] <= '0;
			win_pos_q[1] <= '0;
			for (int k = 0; k < 3; k++) begin
				win_qty_q[k][0] <= '0;
				win_qty_q[k][1] <= '0;
			end
		end else if (in_acc) begin
			win_pos_q[0] <= s_axis_tuser ? '0 : win_pos_q[1];
			win_pos_q[1] <= in_pos;
			for (int k = 0; k < 3; k++) begin
				win_qty_q[k][0] <= s_axis_tuser ? '0 : win_qty_q[k][1];
				win_qty_q[k][1] <= in_qty[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dl_q <= {win_pos_q[1][DW-1], win_pos_q[1]} - {win_pos_q[0][DW-1], win_pos_q[0]};
			dr_q <= {in_pos[DW-1], in_pos} - {win_pos_q[1][DW-1], win_pos_q[1]};
			for (int k = 0; k < 3; k++) begin
				dq_l_q[k] <= {win_qty_q[k][1][DW-1], win_qty_q[k][1]}
					- {win_qty_q[k][0][DW-1], win_qty_q[k][0]};
				dq_r_q[k] <= {in_qty[k][DW-1], in_qty[k]}
					- {win_qty_q[k][1][DW-1], win_qty_q[k][1]};
			end
		end
		if (state_q == mmsl_pkg::ST_PREP) begin
			fault_q <= (dl_q <= 0) || (dr_q <= 0);
			for (int k = 0; k < 3; k++) begin
				neg_l_q[k] <= dq_l_q[k][DW];
				neg_r_q[k] <= dq_r_q[k][DW];
				mag_l_q[k] <= dq_l_q[k][DW] ? -dq_l_q[k] : dq_l_q[k];
				mag_r_q[k] <= dq_r_q[k][DW] ? -dq_r_q[k] : dq_r_q[k];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		mmsl_div #(
			.DATA_WIDTH    (DATA_WIDTH),
			.FRACTION_BITS (FRACTION_BITS)
		) u_div_l (
			.clk     (clk),
			.ctrl    (div_ctrl),
			.mag     (mag_l_q[g]),
			.neg     (neg_l_q[g]),
			.spacing (dl_q[DW-1:0]),
			.slope   (sl[g])
		);

		mmsl_div #(
			.DATA_WIDTH    (DATA_WIDTH),
			.FRACTION_BITS (FRACTION_BITS)
		) u_div_r (
			.clk     (clk),
			.ctrl    (div_ctrl),
			.mag     (mag_r_q[g]),
			.neg     (neg_r_q[g]),
			.spacing (dr_q[DW-1:0]),
			.slope   (sr[g])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!sl[k][DW-1] && |sl[k] && !sr[k][DW-1] && |sr[k]) begin
				mm[k] = ($signed(sl[k]) < $signed(sr[k])) ? sl[k] : sr[k];
			end else if (sl[k][DW-1] && sr[k][DW-1]) begin
				mm[k] = ($signed(sl[k]) > $signed(sr[k])) ? sl[k] : sr[k];
			end else begin
				mm[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fault_q <= fault_q;
			for (int k = 0; k < 3; k++) begin
				out_slope_q[k] <= fault_q ? '0 : mm[k];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_fault_q;
	assign m_axis_tdata  = OUT_W'({out_slope_q[2], out_slope_q[1], out_slope_q[0]});

	`MMSL_ASSERT_SAME(a_fault_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata == '0, "faulted result carries nonzero slopes")
	`MMSL_ASSERT_NEXT(a_restart_fill, clk, arst_n, in_acc && s_axis_tuser,
		fill_q == 2'd1, "restart did not leave a single point in the window")
	`MMSL_ASSERT_SAME(a_fill_range, clk, arst_n, 1'b1,
		fill_q != 2'd3, "window fill count out of range")
	`MMSL_ASSERT_NEXT(a_div_steps, clk, arst_n,
		state_q == mmsl_pkg::ST_DIV && cnt_q != CNT_LAST,
		state_q == mmsl_pkg::ST_DIV, "division ended before all quotient bits")
	`MMSL_ASSERT_SAME(a_busy_no_accept, clk, arst_n, state_q != mmsl_pkg::ST_IDLE,
		!s_axis_tready, "input taken while a point is in flight")

endmodule

// ===== rtl/core/mmsl_div.sv =====
// ----------------------------------------------------------------------------
// Minmod slope limiter bit-serial divider
// Restoring division of a scaled magnitude by a spacing, one quotient bit per
// cycle, with saturation and sign applied on the finishing cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmsl_div #(
	parameter int unsigned DATA_WIDTH    = mmsl_pkg::DATA_WIDTH_DEF,
	parameter int unsigned FRACTION_BITS = mmsl_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  mmsl_pkg::mmsl_div_ctrl_t      ctrl,
	input  logic [DATA_WIDTH:0]           mag,
	input  logic                          neg,
	input  logic [DATA_WIDTH-1:0]         spacing,
	output logic [DATA_WIDTH-1:0]         slope
);

	localparam int unsigned DVW = DATA_WIDTH + 1 + FRACTION_BITS;

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] sh_q;
	logic [DATA_WIDTH-1:0] spc_q;
	logic                  ovf_q;
	logic                  neg_q;
	logic [DATA_WIDTH-1:0] slope_q;

	logic [DVW-1:0]        dvd;
	logic [DVW-1:0]        hi;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH+1:0] diff;
	logic                  ge;
	logic                  sat;
	logic [DATA_WIDTH-1:0] sat_val;
	logic [DATA_WIDTH-1:0] fin_val;

	always_comb begin
		dvd   = DVW'(mag) << FRACTION_BITS;
		hi    = dvd >> DATA_WIDTH;
		trial = {rem_q, sh_q[DATA_WIDTH-1]};
		diff  = {1'b0, trial} - {2'b00, spc_q};
		ge    = ~diff[DATA_WIDTH+1];
		if (neg_q) begin
			sat     = ovf_q | (sh_q[DATA_WIDTH-1] & (|sh_q[DATA_WIDTH-2:0]));
			sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
			fin_val = -sh_q;
		end else begin
			sat     = ovf_q | sh_q[DATA_WIDTH-1];
			sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
			fin_val = sh_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ovf_q <= (hi >= DVW'(spacing));
			rem_q <= hi[DATA_WIDTH-1:0];
			sh_q  <= dvd[DATA_WIDTH-1:0];
			spc_q <= spacing;
			neg_q <= neg;
		end else if (ctrl.step) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			sh_q  <= {sh_q[DATA_WIDTH-2:0], ge};
		end
		if (ctrl.finish) begin
			slope_q <= sat ? sat_val : fin_val;
		end
	end

	assign slope = slope_q;

endmodule
